@@ hdl/pfd_pkg.sv @@
package pfd_pkg;

  // frame length and register reset values (8 timer ticks per microsecond)
  localparam int unsigned NumChannelsDef = 8;
  localparam logic [7:0]  SyncGapReset   = 8'd42;
  localparam logic [15:0] MinWidthReset  = 16'd5600;
  localparam logic [15:0] MaxWidthReset  = 16'd18400;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SYNC_GAP  = 2'd0,
    CFG_MIN_WIDTH = 2'd1,
    CFG_MAX_WIDTH = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  sync_gap_threshold;
    logic [15:0] min_pulse_width;
    logic [15:0] max_pulse_width;
  } cfg_t;

  typedef struct packed {
    logic [15:0] capture_time;
    logic [7:0]  coarse_time;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  channel_index;
    logic [15:0] pulse_width;
    logic        last_channel;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_HOLD
  } fsm_state_e;

endpackage

@@ hdl/pfd_width_mem.sv @@
module pfd_width_mem #(
  parameter int unsigned NUM_CHANNELS = pfd_pkg::NumChannelsDef,
  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  logic            clk_i,
  input  logic            wr_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [15:0]     wr_data_i,
  input  logic            rd_en_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic [15:0]     rd_data_o
);

  logic [15:0] mem_q [NUM_CHANNELS];
  logic [15:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/pfd_frame_fsm.sv @@
module pfd_frame_fsm #(
  parameter int unsigned NUM_CHANNELS = pfd_pkg::NumChannelsDef,
  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1,
  localparam int unsigned PhW  = $clog2(NUM_CHANNELS + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pfd_pkg::cfg_t       cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pfd_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pfd_pkg::out_item_t  out_item_o,
  output logic                mem_wr_en_o,
  output logic [IdxW-1:0]     mem_wr_addr_o,
  output logic [15:0]         mem_wr_data_o,
  output logic                mem_rd_en_o,
  output logic [IdxW-1:0]     mem_rd_addr_o,
  input  logic [15:0]         mem_rd_data_i
);

  pfd_pkg::fsm_state_e state_q, state_d;
  logic [PhW-1:0]  phase_q, phase_d;
  logic [15:0]     prev_q, prev_d;
  logic [7:0]      sync_ref_q, sync_ref_d;
  logic [IdxW-1:0] cnt_q, cnt_d;

  logic        in_acc;
  logic        out_acc;
  logic [15:0] width;
  logic [7:0]  gap;
  logic        width_ok;
  logic        frame_full;
  logic        cnt_last;

  assign in_acc     = in_valid_i && (state_q == pfd_pkg::ST_IDLE);
  assign out_acc    = out_valid_o && !out_stall_i;
  assign width      = in_item_i.capture_time - prev_q;
  assign gap        = in_item_i.coarse_time - sync_ref_q;
  assign width_ok   = (width >= cfg_i.min_pulse_width) && (width <= cfg_i.max_pulse_width);
  assign frame_full = (phase_q == PhW'(NUM_CHANNELS));
  assign cnt_last   = (cnt_q == IdxW'(NUM_CHANNELS - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pfd_pkg::ST_IDLE;
      phase_q    <= '0;
      prev_q     <= '0;
      sync_ref_q <= '0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      prev_q     <= prev_d;
      sync_ref_q <= sync_ref_d;
      cnt_q      <= cnt_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    phase_d       = phase_q;
    prev_d        = prev_q;
    sync_ref_d    = sync_ref_q;
    cnt_d         = cnt_q;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = IdxW'(phase_q - PhW'(1));
    mem_wr_data_o = width;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = cnt_q;
    in_stall_o    = (state_q != pfd_pkg::ST_IDLE);
    out_valid_o   = (state_q == pfd_pkg::ST_HOLD);

    unique case (state_q)
      pfd_pkg::ST_IDLE: begin
        if (in_acc) begin
          prev_d = in_item_i.capture_time;
          if (phase_q == '0) begin
            // hunting: every event moves the coarse reference
            sync_ref_d = in_item_i.coarse_time;
            if (gap > cfg_i.sync_gap_threshold) begin
              phase_d = PhW'(1);
            end
          end else if (!width_ok) begin
            phase_d    = '0;
            sync_ref_d = in_item_i.coarse_time;
          end else begin
            mem_wr_en_o = 1'b1;
            if (frame_full) begin
              phase_d    = '0;
              sync_ref_d = in_item_i.coarse_time;
              cnt_d      = '0;
              state_d    = pfd_pkg::ST_READ;
            end else begin
              phase_d = phase_q + PhW'(1);
            end
          end
        end
      end
      pfd_pkg::ST_READ: begin
        mem_rd_en_o = 1'b1;
        state_d     = pfd_pkg::ST_HOLD;
      end
      pfd_pkg::ST_HOLD: begin
        if (out_acc) begin
          if (cnt_last) begin
            state_d = pfd_pkg::ST_IDLE;
          end else begin
            cnt_d   = cnt_q + IdxW'(1);
            state_d = pfd_pkg::ST_READ;
          end
        end
      end
      default: state_d = pfd_pkg::ST_IDLE;
    endcase
  end

  assign out_item_o.channel_index = 4'(cnt_q);
  assign out_item_o.pulse_width   = mem_rd_data_i;
  assign out_item_o.last_channel  = cnt_last;

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PhW'(NUM_CHANNELS))
    else $error("frame phase beyond channel count");

  a_no_input_while_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input open while a result is shown");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_item_o.last_channel) |=> (!in_stall_o && !out_valid_o))
    else $error("decoder not idle after last channel");

  a_frame_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mem_wr_en_o && frame_full) |=> (cnt_q == '0 && phase_q == '0))
    else $error("emission does not start at channel zero");
`endif

endmodule

@@ hdl/ppm_frame_decoder_top.sv @@
// channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------------
// in       | in_valid_i / in_stall_o    | in_item_i: capture_time, coarse_time
// out      | out_valid_o / out_stall_i  | out_item_o: channel_index, pulse_width,
//          |                            |   last_channel
// cfg      | cfg_we_i                   | cfg_index_i, cfg_wdata_i
//
// an item that completes no frame leaves the decoder idle, and the next one may follow
// in the next cycle; the item that completes a frame is followed by NUM_CHANNELS
// results, each a width store read and then an output state (ST_READ, ST_HOLD), so the
// input stays stalled until the last result has been taken, output stalls included
// widths live in a one-port-write, one-port-read memory with registered read data
// reset clears control state and loads the register defaults; the width memory is
// not cleared, every entry emitted is written earlier in the same frame
module ppm_frame_decoder_top #(
  parameter int unsigned NUM_CHANNELS = pfd_pkg::NumChannelsDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pfd_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pfd_pkg::CfgDataW-1:0]   cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  pfd_pkg::in_item_t              in_item_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output pfd_pkg::out_item_t             out_item_o
);

  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  pfd_pkg::cfg_t   cfg_q, cfg_d;
  logic            mem_wr_en;
  logic [IdxW-1:0] mem_wr_addr;
  logic [15:0]     mem_wr_data;
  logic            mem_rd_en;
  logic [IdxW-1:0] mem_rd_addr;
  logic [15:0]     mem_rd_data;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        pfd_pkg::CFG_SYNC_GAP:  cfg_d.sync_gap_threshold = cfg_wdata_i[7:0];
        pfd_pkg::CFG_MIN_WIDTH: cfg_d.min_pulse_width    = cfg_wdata_i;
        pfd_pkg::CFG_MAX_WIDTH: cfg_d.max_pulse_width    = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_gap_threshold <= pfd_pkg::SyncGapReset;
      cfg_q.min_pulse_width    <= pfd_pkg::MinWidthReset;
      cfg_q.max_pulse_width    <= pfd_pkg::MaxWidthReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pfd_frame_fsm #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .in_item_i     (in_item_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_item_o    (out_item_o),
    .mem_wr_en_o   (mem_wr_en),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_en_o   (mem_rd_en),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_rd_data_i (mem_rd_data)
  );

  pfd_width_mem #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

endmodule
